[hw/rtl/mpva_pkg.sv]
// Shared types and constants for the MIDI parser and voice allocator.
// Depends on nothing; the parser, allocator and top level import it.
`timescale 1ns / 1ps

package mpva_pkg;

	// Upper nibbles of the channel status bytes that are decoded
	localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
	localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
	localparam logic [3:0] STAT_CONTROL  = 4'hB;
	localparam logic [3:0] STAT_BEND     = 4'hE;

	// Width of a voice number inside the allocator (up to 32 voices)
	localparam int VIDX_W = 5;

	// Depth of the message queue and of the result queue
	localparam int MSG_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	typedef enum logic [2:0] {
		CMD_OTHER    = 3'd0,
		CMD_NOTE_OFF = 3'd1,
		CMD_NOTE_ON  = 3'd2,
		CMD_CONTROL  = 3'd3,
		CMD_BEND     = 3'd4
	} cmd_t;

	// Operation handed from the parser to the allocator
	typedef enum logic [1:0] {
		OP_ASSIGN  = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CONTROL = 2'd2,
		OP_BEND    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_ASSIGNED = 3'd0,
		KIND_DROPPED  = 3'd1,
		KIND_RELEASED = 3'd2,
		KIND_CONTROL  = 3'd3,
		KIND_BEND     = 3'd4
	} kind_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] d1;
		logic [6:0] d2;
	} msg_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  voice_index;
		logic [7:0]  released_mask;
		logic [6:0]  note_number;
		logic [6:0]  controller_number;
		logic [6:0]  controller_value;
		logic [13:0] bend_value;
	} result_t;

endpackage

[hw/rtl/mpva_fifo.sv]
// Small register queue with push/full and pop/empty sides.
// Depends on nothing; used for the message queue and the result queue.
`timescale 1ns / 1ps

module mpva_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	// Qualify both sides of a transfer
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rd_ptr_q];

	// Store the incoming entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill level beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue fill level did not grow on push");

endmodule

[hw/rtl/mpva_front.sv]
// Byte parser: tracks running status and pairs data bytes into messages.
// Depends on mpva_pkg for the command, operation and message types.
`timescale 1ns / 1ps

module mpva_front import mpva_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] midi_byte,
	output logic       msg_push,
	output msg_t       msg
);

	cmd_t       cmd_q;
	cmd_t       cmd_dec;
	logic       slot_valid_q;
	logic [6:0] slot_q;
	logic       is_status;
	logic       pair_done;

	assign is_status = midi_byte[7];
	assign pair_done = accept && !is_status && slot_valid_q;

	// Decode the status nibble
	always_comb begin
		unique case (midi_byte[7:4])
			STAT_NOTE_OFF: cmd_dec = CMD_NOTE_OFF;
			STAT_NOTE_ON:  cmd_dec = CMD_NOTE_ON;
			STAT_CONTROL:  cmd_dec = CMD_CONTROL;
			STAT_BEND:     cmd_dec = CMD_BEND;
			default:       cmd_dec = CMD_OTHER;
		endcase
	end

	// Classify a completed pair; unknown commands are dropped here
	always_comb begin
		msg.d1 = slot_q;
		msg.d2 = midi_byte[6:0];
		msg.op = OP_CONTROL;
		msg_push = 1'b0;
		unique case (cmd_q)
			CMD_NOTE_ON: begin
				msg.op   = (midi_byte[6:0] != 7'd0) ? OP_ASSIGN : OP_RELEASE;
				msg_push = pair_done;
			end
			CMD_NOTE_OFF: begin
				msg.op   = OP_RELEASE;
				msg_push = pair_done;
			end
			CMD_CONTROL: begin
				msg.op   = OP_CONTROL;
				msg_push = pair_done;
			end
			CMD_BEND: begin
				msg.op   = OP_BEND;
				msg_push = pair_done;
			end
			default: begin
				msg_push = 1'b0;
			end
		endcase
	end

	// Hold the first data byte of a pair
	always_ff @(posedge clk) begin
		if (accept && !is_status && !slot_valid_q) begin
			slot_q <= midi_byte[6:0];
		end
	end

	// Update running status and the data slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q        <= CMD_OTHER;
			slot_valid_q <= 1'b0;
		end else if (accept) begin
			if (is_status) begin
				cmd_q        <= cmd_dec;
				slot_valid_q <= 1'b0;
			end else begin
				slot_valid_q <= !slot_valid_q;
			end
		end
	end

endmodule

[hw/rtl/mpva_back.sv]
// Voice allocator: carries out parsed messages against the voice table.
// Depends on mpva_pkg for the message and result types.
`timescale 1ns / 1ps

module mpva_back import mpva_pkg::*; #(
	parameter int VOICE_COUNT = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    msg_valid,
	input  msg_t    msg,
	output logic    msg_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res
);

	localparam int MW = (VOICE_COUNT > 8) ? VOICE_COUNT : 8;

	logic [VOICE_COUNT-1:0] active_q;
	logic [6:0]             note_q [VOICE_COUNT];
	logic [VOICE_COUNT-1:0] free_vec;
	logic [VOICE_COUNT-1:0] first_free;
	logic [VOICE_COUNT-1:0] match;
	logic [MW-1:0]          match_ext;
	logic [VIDX_W-1:0]      free_idx;
	logic                   any_free;
	logic                   fire;

	assign fire     = msg_valid && !res_full;
	assign msg_pop  = fire;
	assign res_push = fire;

	// Find the lowest free voice
	assign free_vec   = ~active_q;
	assign first_free = free_vec & (~free_vec + 1'b1);
	assign any_free   = |free_vec;

	always_comb begin
		free_idx = '0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			if (first_free[v]) begin
				free_idx = free_idx | VIDX_W'(v);
			end
		end
	end

	// Compare the note against every active voice
	always_comb begin
		for (int v = 0; v < VOICE_COUNT; v++) begin
			match[v] = active_q[v] && (note_q[v] == msg.d1);
		end
	end

	assign match_ext = MW'(match);

	// Build the result item
	always_comb begin
		res = '0;
		unique case (msg.op)
			OP_ASSIGN: begin
				res.kind        = any_free ? KIND_ASSIGNED : KIND_DROPPED;
				res.voice_index = any_free ? free_idx[2:0] : 3'd0;
				res.note_number = msg.d1;
			end
			OP_RELEASE: begin
				res.kind          = KIND_RELEASED;
				res.released_mask = match_ext[7:0];
				res.note_number   = msg.d1;
			end
			OP_CONTROL: begin
				res.kind              = KIND_CONTROL;
				res.controller_number = msg.d1;
				res.controller_value  = msg.d2;
			end
			OP_BEND: begin
				res.kind       = KIND_BEND;
				res.bend_value = {msg.d2, msg.d1};
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// Store the note in the voice being taken
	always_ff @(posedge clk) begin
		for (int v = 0; v < VOICE_COUNT; v++) begin
			if (fire && msg.op == OP_ASSIGN && first_free[v]) begin
				note_q[v] <= msg.d1;
			end
		end
	end

	// Take or free voices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
		end else if (fire) begin
			if (msg.op == OP_ASSIGN) begin
				active_q <= active_q | first_free;
			end else if (msg.op == OP_RELEASE) begin
				active_q <= active_q & ~match;
			end
		end
	end

	a_assign_one: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && msg.op == OP_ASSIGN && any_free)
		|=> ($countones(active_q) == $countones($past(active_q)) + 1))
		else $error("note assignment did not take exactly one voice");

	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && msg.op == OP_RELEASE) |=> ((active_q & $past(match)) == '0))
		else $error("matching voice still active after release");

	a_idle_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(active_q))
		else $error("voice table changed without a transfer");

endmodule

[hw/rtl/midi_parser_voice_allocator.sv]
// MIDI byte parser with polyphonic voice allocation, top level.
// Depends on mpva_pkg, mpva_front, mpva_fifo and mpva_back.
//
// Input channel: one raw MIDI byte per transfer on midi_byte, taken at a
// clock edge with push high and full low. Status bytes set the running
// command; data bytes are paired. A completed pair yields at most one
// result: note assigned or dropped, note released (with a mask of freed
// voices), control change, or pitch bend.
// Result channel: a result sits on the result ports while empty is low and
// is removed at an edge with pop high. One byte per cycle is sustained
// while full stays low. The edge that transfers the byte completing a pair
// writes its message into the message queue; while the message is at the
// head of that queue, the allocator acts on it and, at an edge where the
// result queue is not full, updates the voice table and writes the result
// queue, whose head drives the result ports.
// When the receiver stalls, the two-entry result queue fills, the allocator
// holds, the two-entry message queue fills and full rises; no byte or
// result is lost. Reset clears the running command, the data slot, all
// voices and both queues; the block takes bytes from the first cycle.
`timescale 1ns / 1ps

module midi_parser_voice_allocator import mpva_pkg::*; #(
	parameter int VOICE_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [7:0]  midi_byte,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output logic [2:0]  event_kind,
	output logic [2:0]  voice_index,
	output logic [7:0]  released_mask,
	output logic [6:0]  note_number,
	output logic [6:0]  controller_number,
	output logic [6:0]  controller_value,
	output logic [13:0] bend_value
);

	logic    accept;
	logic    msg_push;
	msg_t    msg_in;
	logic    msg_full;
	logic    msg_empty;
	logic    msg_pop;
	msg_t    msg_head;
	logic    res_push;
	result_t res_in;
	logic    res_full;
	result_t res_head;

	// Stall input whenever the message queue is full
	assign full   = msg_full;
	assign accept = push && !msg_full;

	// Parse bytes into messages
	mpva_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.midi_byte (midi_byte),
		.msg_push  (msg_push),
		.msg       (msg_in)
	);

	// Decouple parser from allocator
	mpva_fifo #(
		.WIDTH ($bits(msg_t)),
		.DEPTH (MSG_DEPTH)
	) u_msg_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (msg_push),
		.wdata  (msg_in),
		.full   (msg_full),
		.pop    (msg_pop),
		.rdata  (msg_head),
		.empty  (msg_empty)
	);

	// Allocate and release voices
	mpva_back #(
		.VOICE_COUNT (VOICE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (!msg_empty),
		.msg       (msg_head),
		.msg_pop   (msg_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	// Hold results for the receiver
	mpva_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign event_kind        = res_head.kind;
	assign voice_index       = res_head.voice_index;
	assign released_mask     = res_head.released_mask;
	assign note_number       = res_head.note_number;
	assign controller_number = res_head.controller_number;
	assign controller_value  = res_head.controller_value;
	assign bend_value        = res_head.bend_value;

endmodule

[test/midi_parser_voice_allocator_test.sv]
// Self-checking testbench for midi_parser_voice_allocator: MIDI byte streams in,
// voice and controller events checked against an in-bench parser and voice table.
// Depends on mpva_pkg and the RTL of the block; reads and writes no files.
`timescale 1ns / 1ps

module midi_parser_voice_allocator_test import mpva_pkg::*;;

	localparam int VOICES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 460;
	localparam int MAX_REPORTS = 40;
	localparam logic [7:0] SLOT_EMPTY = 8'h80;

	// Status nibbles that the block treats as unknown commands
	localparam logic [3:0] STAT_POLY_PRESS = 4'hA;
	localparam logic [3:0] STAT_PROGRAM    = 4'hC;
	localparam logic [3:0] STAT_CHAN_PRESS = 4'hD;
	localparam logic [3:0] STAT_SYSTEM     = 4'hF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic [7:0]  midi_byte = 8'h00;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [2:0]  event_kind;
	logic [2:0]  voice_index;
	logic [7:0]  released_mask;
	logic [6:0]  note_number;
	logic [6:0]  controller_number;
	logic [6:0]  controller_value;
	logic [13:0] bend_value;

	// Stimulus bytes, predicted events, and the parser/voice state behind them
	logic [7:0]  stream_bytes[$];
	result_t     expected_events[$];
	cmd_t        running_cmd;
	logic [7:0]  data_slot;
	logic [VOICES-1:0] voice_busy;
	logic [6:0]  voice_key[VOICES];

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	logic [7:0]  last_status = 8'h00;

	midi_parser_voice_allocator #(.VOICE_COUNT(VOICES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.midi_byte(midi_byte),
		.full(full),
		.pop(pop),
		.empty(empty),
		.event_kind(event_kind),
		.voice_index(voice_index),
		.released_mask(released_mask),
		.note_number(note_number),
		.controller_number(controller_number),
		.controller_value(controller_value),
		.bend_value(bend_value)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Clear the parser and voice table to their reset state
	function automatic void clear_voices();
		running_cmd = CMD_OTHER;
		data_slot = SLOT_EMPTY;
		voice_busy = '0;
		for (int v = 0; v < VOICES; v++)
			voice_key[v] = 7'd0;
	endfunction

	// Advance the parser by one byte and queue the event it causes, if any
	function automatic void parse_byte(input logic [7:0] b);
		result_t ev;
		logic [6:0] d1;
		logic [6:0] d2;
		logic [7:0] mask;
		logic found;
		ev = '0;
		mask = '0;
		found = 1'b0;
		if (b[7]) begin
			case (b[7:4])
				STAT_NOTE_OFF: running_cmd = CMD_NOTE_OFF;
				STAT_NOTE_ON:  running_cmd = CMD_NOTE_ON;
				STAT_CONTROL:  running_cmd = CMD_CONTROL;
				STAT_BEND:     running_cmd = CMD_BEND;
				default:       running_cmd = CMD_OTHER;
			endcase
			data_slot = SLOT_EMPTY;
			return;
		end
		if (data_slot == SLOT_EMPTY) begin
			data_slot = b;
			return;
		end
		d1 = data_slot[6:0];
		d2 = b[6:0];
		data_slot = SLOT_EMPTY;
		if (running_cmd == CMD_NOTE_ON && d2 != 7'd0) begin
			ev.note_number = d1;
			for (int v = 0; v < VOICES; v++) begin
				if (!found && !voice_busy[v]) begin
					found = 1'b1;
					voice_busy[v] = 1'b1;
					voice_key[v] = d1;
					ev.voice_index = v[2:0];
				end
			end
			ev.kind = found ? KIND_ASSIGNED : KIND_DROPPED;
		end else if (running_cmd == CMD_NOTE_ON || running_cmd == CMD_NOTE_OFF) begin
			for (int v = 0; v < VOICES; v++) begin
				if (voice_busy[v] && voice_key[v] == d1) begin
					voice_busy[v] = 1'b0;
					if (v < 8)
						mask[v] = 1'b1;
				end
			end
			ev.kind = KIND_RELEASED;
			ev.released_mask = mask;
			ev.note_number = d1;
		end else if (running_cmd == CMD_CONTROL) begin
			ev.kind = KIND_CONTROL;
			ev.controller_number = d1;
			ev.controller_value = d2;
		end else if (running_cmd == CMD_BEND) begin
			ev.kind = KIND_BEND;
			ev.bend_value = {d2, d1};
		end else begin
			return;
		end
		expected_events.push_back(ev);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Compare the event at the head of the result queue with the oldest prediction
	task automatic check_event();
		result_t want;
		if (expected_events.size() == 0) begin
			report_mismatch("unexpected event, kind", event_kind, -1);
			return;
		end
		want = expected_events.pop_front();
		if (event_kind != want.kind)
			report_mismatch("event_kind", event_kind, want.kind);
		if (voice_index != want.voice_index)
			report_mismatch("voice_index", voice_index, want.voice_index);
		if (released_mask != want.released_mask)
			report_mismatch("released_mask", released_mask, want.released_mask);
		if (note_number != want.note_number)
			report_mismatch("note_number", note_number, want.note_number);
		if (controller_number != want.controller_number)
			report_mismatch("controller_number", controller_number, want.controller_number);
		if (controller_value != want.controller_value)
			report_mismatch("controller_value", controller_value, want.controller_value);
		if (bend_value != want.bend_value)
			report_mismatch("bend_value", bend_value, want.bend_value);
	endtask

	// Random data byte; notes mostly from a narrow range so voices collide
	function automatic logic [7:0] pick_note();
		if ($urandom_range(3) != 0)
			return 8'd48 + 8'($urandom_range(11));
		return 8'($urandom_range(127));
	endfunction

	// Emit the status byte, or at random skip it when running status can reuse the last one
	task automatic put_status(input logic [3:0] stat);
		logic [7:0] s;
		s = {stat, 4'($urandom_range(15))};
		if (last_status[7:4] == stat && $urandom_range(2) != 0)
			return;
		stream_bytes.push_back(s);
		last_status = s;
	endtask

	// Append one message: mostly well formed, some unknown, broken or noise
	task automatic add_message();
		int r;
		r = $urandom_range(99);
		if (r < 45) begin
			put_status(STAT_NOTE_ON);
			stream_bytes.push_back(pick_note());
			stream_bytes.push_back(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 127)));
		end else if (r < 65) begin
			put_status(STAT_NOTE_OFF);
			stream_bytes.push_back(pick_note());
			stream_bytes.push_back(8'($urandom_range(127)));
		end else if (r < 75) begin
			put_status(STAT_CONTROL);
			stream_bytes.push_back(8'($urandom_range(127)));
			stream_bytes.push_back(8'($urandom_range(127)));
		end else if (r < 83) begin
			put_status(STAT_BEND);
			stream_bytes.push_back(8'($urandom_range(127)));
			stream_bytes.push_back(8'($urandom_range(127)));
		end else if (r < 88) begin
			case ($urandom_range(2))
				0: put_status(STAT_POLY_PRESS);
				1: put_status(STAT_PROGRAM);
				default: put_status(STAT_CHAN_PRESS);
			endcase
			stream_bytes.push_back(8'($urandom_range(127)));
			stream_bytes.push_back(8'($urandom_range(127)));
		end else if (r < 92) begin
			put_status(STAT_SYSTEM);
			stream_bytes.push_back(8'($urandom_range(127)));
			stream_bytes.push_back(8'($urandom_range(127)));
		end else if (r < 96) begin
			// Cut a message short after its first data byte
			put_status(STAT_NOTE_ON);
			stream_bytes.push_back(pick_note());
			last_status = 8'h00;
		end else begin
			stream_bytes.push_back(8'($urandom_range(255)));
			last_status = 8'h00;
		end
	endtask

	// Hold until every queued byte is transferred and every event has come
	task automatic drain();
		while (stream_bytes.size() != 0 || push)
			@(negedge clk);
		while (expected_events.size() != 0)
			@(negedge clk);
	endtask

	// Driver: one transfer per accepted edge, random gaps between bytes
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			midi_byte <= 8'h00;
		end else begin
			if (push && !full)
				parse_byte(midi_byte);
			if (!push || !full) begin
				if (stream_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					push <= 1'b1;
					midi_byte <= stream_bytes.pop_front();
				end else begin
					push <= 1'b0;
					midi_byte <= 8'($urandom_range(255));
				end
			end
		end
	end

	// Monitor: check each event transfer, stall pop at random
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_event();
			pop <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("midi_parser_voice_allocator_test NOT OK");
			$finish;
		end
	end

	initial begin
		clear_voices();
		send_idle_pct = 26;
		recv_idle_pct = 66;

		// Data pair with no command since reset: consumed silently
		stream_bytes.push_back(8'h05);
		stream_bytes.push_back(8'h06);
		// Note on at both note extremes, then a zero-velocity release
		stream_bytes.push_back({STAT_NOTE_ON, 4'h0});
		stream_bytes.push_back(8'h00);
		stream_bytes.push_back(8'h7F);
		stream_bytes.push_back(8'h7F);
		stream_bytes.push_back(8'h01);
		stream_bytes.push_back(8'h7F);
		stream_bytes.push_back(8'h00);
		// Note off that matches, then one that matches nothing
		stream_bytes.push_back({STAT_NOTE_OFF, 4'h0});
		stream_bytes.push_back(8'h00);
		stream_bytes.push_back(8'h40);
		stream_bytes.push_back(8'h00);
		stream_bytes.push_back(8'h00);
		// Control change and pitch bend at their extremes
		stream_bytes.push_back({STAT_CONTROL, 4'h0});
		stream_bytes.push_back(8'h7F);
		stream_bytes.push_back(8'h00);
		stream_bytes.push_back({STAT_BEND, 4'hF});
		stream_bytes.push_back(8'h7F);
		stream_bytes.push_back(8'h7F);
		// System byte in the middle of a pair empties the slot
		stream_bytes.push_back({STAT_NOTE_ON, 4'hF});
		stream_bytes.push_back(8'h3C);
		stream_bytes.push_back(8'hFF);
		stream_bytes.push_back(8'h10);
		stream_bytes.push_back(8'h20);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (stream_bytes.size() < PHASE_BYTES)
			add_message();
		drain();

		send_idle_pct = 66;
		recv_idle_pct = 26;
		while (stream_bytes.size() < PHASE_BYTES)
			add_message();
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (stream_bytes.size() < PHASE_BYTES)
			add_message();
		drain();

		// Let any stray event surface before the verdict
		repeat (10) @(negedge clk);
		if (mismatch_count == 0)
			$display("midi_parser_voice_allocator_test OK");
		else
			$display("midi_parser_voice_allocator_test NOT OK");
		$finish;
	end

endmodule
